>>> rtl/core/btree_internal_node_table_unit_defines.svh
// Assertion macros shared by the node table RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef BTREE_INTERNAL_NODE_TABLE_UNIT_DEFINES_SVH
`define BTREE_INTERNAL_NODE_TABLE_UNIT_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define BTNT_ASSERT_CLK(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Concurrent assertion on the block clock and reset (clk, arst_n).
`define BTNT_ASSERT(label, prop, msg) \
	`BTNT_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

>>> rtl/core/btnt_pkg.sv
// Shared types, constants and the composite key compare for the node table.
// No dependencies; imported by every module of the block.
package btnt_pkg;

	localparam int DEF_MAX_ENTRIES = 256;
	localparam int KEY_W           = 32;
	localparam int ROW_W           = 32;
	localparam int CHILD_W         = 32;
	localparam int CNT_OUT_W       = 9;
	localparam int IN_DATA_W       = 104;
	localparam int OUT_DATA_W      = 48;
	localparam int OR_FAN          = 16;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL,
		ST_RED_A,
		ST_RED_B,
		ST_LOAD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [ROW_W-1:0]   row;
		logic [CHILD_W-1:0] child;
	} entry_t;

	// hit flag in the top bit, child page below
	typedef logic [CHILD_W:0] hit_word_t;

	typedef struct packed {
		logic upd;
		logic eval;
		logic lookup;
	} cell_ctl_t;

	// true when a is strictly below b: key first, then row id
	function automatic logic key_less(entry_t a, entry_t b);
		logic res;
		if (a.key != b.key) begin
			res = a.key < b.key;
		end else begin
			res = a.row < b.row;
		end
		return res;
	endfunction

endpackage

>>> rtl/core/btnt_cell.sv
// One slot of the sorted entry row: holds an entry, compares it with the item.
// Depends on btnt_pkg; instantiated once per slot by the top level.
module btnt_cell import btnt_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int INDEX       = 0,
	localparam int CW         = $clog2(MAX_ENTRIES + 1)
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [CW-1:0] count,
	input  entry_t        new_ent,
	input  entry_t        prev_ent,
	input  logic          prev_greater,
	output entry_t        ent,
	output logic          greater,
	output hit_word_t     hit
);

	entry_t    ent_q;
	hit_word_t hit_s1;
	logic      occ;
	logic      first;

	assign occ = count > CW'(INDEX);
	// an empty slot counts as greater, so the row stays monotone
	assign greater = occ ? key_less(new_ent, ent_q) : 1'b1;
	assign first = occ && greater && !prev_greater;

	always_ff @(posedge clk) begin
		if (ctl.upd && greater) begin
			ent_q <= prev_greater ? prev_ent : new_ent;
		end
		if (ctl.eval) begin
			hit_s1 <= (ctl.lookup && first) ? {1'b1, ent_q.child} : '0;
		end
	end

	assign ent = ent_q;
	assign hit = hit_s1;

endmodule

>>> rtl/core/btnt_or_tree.sv
// Registered two-level OR reduction of the per-slot lookup hits.
// Depends on btnt_pkg; ORs groups of OR_FAN leaves, then groups of OR_FAN of those groups.
module btnt_or_tree import btnt_pkg::*; #(
	parameter int N = DEF_MAX_ENTRIES
) (
	input  logic      clk,
	input  logic      en_a,
	input  logic      en_b,
	input  hit_word_t leaf [N],
	output hit_word_t result
);

	localparam int NA = (N + OR_FAN - 1) / OR_FAN;
	localparam int NB = (NA + OR_FAN - 1) / OR_FAN;

	hit_word_t grp_a_s2 [NA];
	hit_word_t grp_b_s3 [NB];
	hit_word_t grp_a_d  [NA];
	hit_word_t grp_b_d  [NB];

	always_comb begin
		for (int g = 0; g < NA; g++) begin
			grp_a_d[g] = '0;
			for (int m = 0; m < OR_FAN; m++) begin
				if (g * OR_FAN + m < N) begin
					grp_a_d[g] = grp_a_d[g] | leaf[g * OR_FAN + m];
				end
			end
		end
	end

	always_comb begin
		for (int g = 0; g < NB; g++) begin
			grp_b_d[g] = '0;
			for (int m = 0; m < OR_FAN; m++) begin
				if (g * OR_FAN + m < NA) begin
					grp_b_d[g] = grp_b_d[g] | grp_a_s2[g * OR_FAN + m];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_a) begin
			grp_a_s2 <= grp_a_d;
		end
		if (en_b) begin
			grp_b_s3 <= grp_b_d;
		end
	end

	always_comb begin
		result = '0;
		for (int g = 0; g < NB; g++) begin
			result = result | grp_b_s3[g];
		end
	end

endmodule

>>> rtl/core/btree_internal_node_table_unit.sv
// B+tree internal node table: up to MAX_ENTRIES (key, row id, child) entries
// kept sorted in a row of slots, each with its own compare. An insert, lookup
// or clear runs one item at a time: the item is registered, compared and
// shifted across the slot row, its lookup hit is collected by the registered
// OR stages, and the result is loaded into the output register. The block
// then holds the result until its transaction completes and takes the next
// item in the following cycle.
// No clearing pass after reset; the table is empty.
module btree_internal_node_table_unit import btnt_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// command[1:0], search_key[33:2], search_row[65:34], child_in[97:66], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// ok[0], child_out[32:1], entry_count[41:33], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CHILD_W-1:0]    cfg_data
);

	`include "btree_internal_node_table_unit_defines.svh"

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	state_t              state_q, state_d;
	logic [1:0]          cmd_q;
	entry_t              item_q;
	logic [CW-1:0]       count_q;
	logic                ok_q;
	logic [CHILD_W-1:0]  right_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                full;
	cell_ctl_t           ctl;
	entry_t              cell_ent [MAX_ENTRIES];
	logic                cell_gt  [MAX_ENTRIES];
	hit_word_t           cell_hit [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] hit_vec;
	hit_word_t           tree_res;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;
	logic [CHILD_W-1:0]  child_sel;

	assign full = count_q == CW'(MAX_ENTRIES);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_CELL;
				end
			end
			ST_CELL: begin
				ctl.eval = 1'b1;
				ctl.lookup = cmd_q == CMD_LOOKUP;
				ctl.upd = (cmd_q == CMD_INSERT) && !full;
				state_d = ST_RED_A;
			end
			ST_RED_A: state_d = ST_RED_B;
			ST_RED_B: state_d = ST_LOAD;
			ST_LOAD: state_d = ST_OUT;
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= s_tdata[1:0];
			item_q.key <= s_tdata[33:2];
			item_q.row <= s_tdata[65:34];
			item_q.child <= s_tdata[97:66];
		end
		// the second OR stage has settled by now
		if (state_q == ST_LOAD) begin
			m_tdata_q <= {6'b0, cnt_ext[CNT_OUT_W-1:0], child_sel, ok_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ok_q <= 1'b1;
			right_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				right_q <= cfg_data;
			end
			if (state_q == ST_CELL) begin
				ok_q <= !((cmd_q == CMD_INSERT) && full);
				case (cmd_q)
					CMD_INSERT: begin
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end
					CMD_CLEAR: count_q <= '0;
					default: count_q <= count_q;
				endcase
			end
		end
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			btnt_cell #(.MAX_ENTRIES(MAX_ENTRIES), .INDEX(i)) u_cell (
				.clk          (clk),
				.ctl          (ctl),
				.count        (count_q),
				.new_ent      (item_q),
				.prev_ent     (item_q),
				.prev_greater (1'b0),
				.ent          (cell_ent[i]),
				.greater      (cell_gt[i]),
				.hit          (cell_hit[i])
			);
		end else begin : g_body
			btnt_cell #(.MAX_ENTRIES(MAX_ENTRIES), .INDEX(i)) u_cell (
				.clk          (clk),
				.ctl          (ctl),
				.count        (count_q),
				.new_ent      (item_q),
				.prev_ent     (cell_ent[i-1]),
				.prev_greater (cell_gt[i-1]),
				.ent          (cell_ent[i]),
				.greater      (cell_gt[i]),
				.hit          (cell_hit[i])
			);
		end
		assign hit_vec[i] = cell_hit[i][CHILD_W];
	end

	btnt_or_tree #(.N(MAX_ENTRIES)) u_or_tree (
		.clk    (clk),
		.en_a   (state_q == ST_RED_A),
		.en_b   (state_q == ST_RED_B),
		.leaf   (cell_hit),
		.result (tree_res)
	);

	// no stored entry above the key: fall back to the right child
	always_comb begin
		child_sel = '0;
		if (cmd_q == CMD_LOOKUP) begin
			child_sel = tree_res[CHILD_W] ? tree_res[CHILD_W-1:0] : right_q;
		end
	end

	assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_q};
	assign m_tdata = m_tdata_q;

	`BTNT_ASSERT(a_count_bound, count_q <= CW'(MAX_ENTRIES), "entry count above capacity")
	`BTNT_ASSERT(a_full_reject, (state_q == ST_CELL && cmd_q == CMD_INSERT && full) |=> (count_q == $past(count_q) && !ok_q), "full insert changed the table")
	`BTNT_ASSERT(a_single_hit, (state_q == ST_RED_A) |-> $onehot0(hit_vec), "more than one slot hit on lookup")
	`BTNT_ASSERT(a_latency, (s_tvalid && s_tready) |-> ##5 m_tvalid, "result not ready five cycles after acceptance")

endmodule

>>> test/tb.sv
// Self-checking bench for the B+tree internal node table: stream driver, result monitor
// and a cycle-free model of the sorted table that predicts every result.
// Depends on btnt_pkg and btree_internal_node_table_unit.
module tb;
	import btnt_pkg::*;

	localparam int          TABLE_DEPTH = 256;
	localparam logic [1:0]  CMD_UNUSED  = 2'd3;
	localparam int          HOLD_AT     = 200;
	localparam int          HOLD_CYCLES = 400;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [KEY_W-1:0]   key;
		logic [ROW_W-1:0]   row;
		logic [CHILD_W-1:0] child;
	} node_op_t;

	typedef struct packed {
		logic               ok;
		logic [CHILD_W-1:0] child;
		logic [8:0]         count;
	} node_resp_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CHILD_W-1:0]    cfg_data = '0;

	btree_internal_node_table_unit #(.MAX_ENTRIES(TABLE_DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// table model
	logic [KEY_W-1:0]   tbl_key   [TABLE_DEPTH];
	logic [ROW_W-1:0]   tbl_row   [TABLE_DEPTH];
	logic [CHILD_W-1:0] tbl_child [TABLE_DEPTH];
	int                 tbl_count = 0;
	logic [CHILD_W-1:0] right_page = '0;

	node_op_t    ops_to_send[$];
	node_resp_t  awaited_resps[$];
	node_op_t    op_on_bus;
	int unsigned accepted_ops = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned mismatches = 0;

	// generator-side shadow of the stored keys, used to aim lookups at real entries
	logic [KEY_W-1:0] gen_keys[$];
	logic [ROW_W-1:0] gen_rows[$];

	function automatic int first_above(logic [KEY_W-1:0] k, logic [ROW_W-1:0] r);
		int i;
		for (i = 0; i < tbl_count; i++) begin
			if (k < tbl_key[i] || (k == tbl_key[i] && r < tbl_row[i]))
				return i;
		end
		return tbl_count;
	endfunction

	function automatic node_resp_t node_table_apply(node_op_t op);
		node_resp_t res;
		int pos;
		res.ok = 1'b1;
		res.child = '0;
		case (op.cmd)
			CMD_INSERT: begin
				if (tbl_count >= TABLE_DEPTH) begin
					res.ok = 1'b0;
				end else begin
					pos = first_above(op.key, op.row);
					for (int j = tbl_count; j > pos; j--) begin
						tbl_key[j] = tbl_key[j-1];
						tbl_row[j] = tbl_row[j-1];
						tbl_child[j] = tbl_child[j-1];
					end
					tbl_key[pos] = op.key;
					tbl_row[pos] = op.row;
					tbl_child[pos] = op.child;
					tbl_count++;
				end
			end
			CMD_LOOKUP: begin
				pos = first_above(op.key, op.row);
				res.child = (pos < tbl_count) ? tbl_child[pos] : right_page;
			end
			CMD_CLEAR: tbl_count = 0;
			default: ;
		endcase
		res.count = tbl_count[8:0];
		return res;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2, 3: return $urandom();
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	function automatic void push_op(logic [1:0] cmd, logic [31:0] k, r, c);
		node_op_t op;
		op.cmd = cmd;
		op.key = k;
		op.row = r;
		op.child = c;
		ops_to_send = {ops_to_send, op};
		if (cmd == CMD_INSERT && gen_keys.size() < TABLE_DEPTH) begin
			gen_keys = {gen_keys, k};
			gen_rows = {gen_rows, r};
		end else if (cmd == CMD_CLEAR) begin
			gen_keys.delete();
			gen_rows.delete();
		end
	endfunction

	function automatic void push_lookup();
		int idx;
		logic [31:0] k, r;
		if (gen_keys.size() != 0 && $urandom_range(0, 1)) begin
			idx = $urandom_range(0, gen_keys.size() - 1);
			k = gen_keys[idx];
			r = gen_rows[idx];
			// land just below, on, or just above a stored entry
			case ($urandom_range(0, 2))
				0: r = r - 1;
				1: r = r + 1;
				default: ;
			endcase
		end else begin
			k = pick_word();
			r = pick_word();
		end
		push_op(CMD_LOOKUP, k, r, $urandom());
	endfunction

	function automatic void push_mixed();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 48)
			push_op(CMD_INSERT, pick_word(), pick_word(), $urandom());
		else if (roll < 90)
			push_lookup();
		else if (roll < 95)
			push_op(CMD_CLEAR, $urandom(), $urandom(), $urandom());
		else
			push_op(CMD_UNUSED, $urandom(), $urandom(), $urandom());
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (ops_to_send.size() != 0 || s_tvalid || awaited_resps.size() != 0);
	endtask

	task automatic write_right_page(logic [CHILD_W-1:0] value);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		right_page = value;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// driver: hold each transaction until it is taken, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		node_op_t nxt;
		node_resp_t pred;
		bit calm;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			calm = accepted_ops >= 330 && accepted_ops < 410;
			if (s_tvalid && s_tready) begin
				pred = node_table_apply(op_on_bus);
				awaited_resps = {awaited_resps, pred};
				accepted_ops <= accepted_ops + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (ops_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
					nxt = ops_to_send.pop_front();
					op_on_bus <= nxt;
					s_tvalid <= 1'b1;
					s_tdata <= {{(IN_DATA_W-98){1'b0}}, nxt.child, nxt.row, nxt.key, nxt.cmd};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// one long back-pressure stretch while the sender keeps offering
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && accepted_ops == HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// monitor: compare every result transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		node_resp_t want, got;
		bit calm;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			calm = accepted_ops >= 330 && accepted_ops < 410;
			if (m_tvalid && m_tready) begin
				got.ok = m_tdata[0];
				got.child = m_tdata[32:1];
				got.count = m_tdata[41:33];
				if (awaited_resps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: ok %0b child %h count %0d",
							got.ok, got.child, got.count);
				end else begin
					want = awaited_resps.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected ok %0b child %h count %0d,",
								" got ok %0b child %h count %0d"},
								want.ok, want.child, want.count,
								got.ok, got.child, got.count);
					end
				end
			end
			m_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 7);
		end
	end

	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, unused command, extremes, equal keys, edges of the search
		write_right_page(32'hFFFF_FFFF);
		push_op(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);
		push_op(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(CMD_CLEAR, 32'h0, 32'h0, 32'h0);
		push_op(CMD_INSERT, 32'h0, 32'h0, 32'h0);
		push_op(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(CMD_INSERT, 32'd5, 32'd7, 32'h1111_1111);
		push_op(CMD_INSERT, 32'd5, 32'd7, 32'h2222_2222);
		push_op(CMD_INSERT, 32'd5, 32'd6, 32'h3333_3333);
		push_op(CMD_INSERT, 32'd5, 32'd8, 32'h4444_4444);
		push_op(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);
		push_op(CMD_LOOKUP, 32'd5, 32'd7, 32'h0);
		push_op(CMD_LOOKUP, 32'd5, 32'd6, 32'h0);
		push_op(CMD_LOOKUP, 32'd4, 32'hFFFF_FFFF, 32'h0);
		push_op(CMD_LOOKUP, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0);
		push_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0);
		push_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		push_op(CMD_UNUSED, 32'h0, 32'h0, 32'h0);
		push_op(CMD_LOOKUP, 32'd6, 32'd0, 32'h0);
		push_op(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(CMD_LOOKUP, 32'd5, 32'd7, 32'h0);

		// fill to capacity, then knock on the full table
		write_right_page(32'h0);
		while (gen_keys.size() < TABLE_DEPTH) begin
			if ($urandom_range(0, 9) == 0)
				push_lookup();
			else
				push_op(CMD_INSERT, pick_word(), pick_word(), $urandom());
		end
		repeat (6) begin
			push_op(CMD_INSERT, pick_word(), pick_word(), $urandom());
			push_lookup();
		end
		push_op(CMD_UNUSED, $urandom(), $urandom(), $urandom());
		push_op(CMD_CLEAR, $urandom(), $urandom(), $urandom());
		push_lookup();

		// mixed traffic, with a full drain half way through
		write_right_page($urandom());
		repeat (40) push_mixed();
		wait_idle();
		repeat (40) push_mixed();

		write_right_page(32'hA5A5_5A5A);
		repeat (80) push_mixed();

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && awaited_resps.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
